>>> hw/rtl/dpe_pkg.sv
// Package for the digit panel editor: widths, button bits, mode codes,
// and the result record. No dependencies.
package dpe_pkg;

    localparam int NUM_DIGITS = 5;
    localparam int DIGIT_W    = 4;
    localparam int BTN_W      = 5;
    localparam int MODE_W     = 4;
    localparam int CURSOR_W   = 3;

    // Button bit positions
    localparam int BTN_LEFT  = 4;
    localparam int BTN_RIGHT = 3;
    localparam int BTN_UP    = 2;
    localparam int BTN_DOWN  = 1;
    localparam int BTN_SEND  = 0;

    // Mode switch codes with their own digit rules
    localparam logic [MODE_W-1:0] MODE_0 = 4'd0;
    localparam logic [MODE_W-1:0] MODE_1 = 4'd1;
    localparam logic [MODE_W-1:0] MODE_2 = 4'd2;
    localparam logic [MODE_W-1:0] MODE_3 = 4'd3;
    localparam logic [MODE_W-1:0] MODE_6 = 4'd6;
    localparam logic [MODE_W-1:0] MODE_8 = 4'd8;
    localparam logic [MODE_W-1:0] MODE_9 = 4'd9;

    typedef logic [DIGIT_W-1:0]  t_digit;
    typedef logic [CURSOR_W-1:0] t_cursor;

    typedef struct packed {
        t_digit  [NUM_DIGITS-1:0] digits;
        t_cursor                  cursor;
        t_cursor                  last_index;
        logic                     sending;
        logic                     read_request;
        logic                     stop_pulse;
    } t_result;

endpackage

>>> hw/rtl/dpe_if.sv
// Handshake channels of the digit panel editor: button events in, panel out.
// Depends on dpe_pkg.
interface dpe_in_if;
    import dpe_pkg::*;

    logic              valid;
    logic              ready;
    logic [BTN_W-1:0]  buttons;
    logic [MODE_W-1:0] mode;
    logic              send_clear;

    modport source (output valid, buttons, mode, send_clear, input ready);
    modport sink   (input valid, buttons, mode, send_clear, output ready);
endinterface

interface dpe_out_if;
    import dpe_pkg::*;

    logic    valid;
    logic    ready;
    t_digit  digit0;
    t_digit  digit1;
    t_digit  digit2;
    t_digit  digit3;
    t_digit  digit4;
    t_cursor cursor;
    t_cursor last_index;
    logic    sending;
    logic    read_request;
    logic    stop_pulse;

    modport source (output valid, digit0, digit1, digit2, digit3, digit4, cursor,
                    last_index, sending, read_request, stop_pulse, input ready);
    modport sink   (input valid, digit0, digit1, digit2, digit3, digit4, cursor,
                    last_index, sending, read_request, stop_pulse, output ready);
endinterface

>>> hw/rtl/digit_panel_editor.sv
// Digit panel editor: takes one button event per transfer and returns one
// panel snapshot per event. A new event is taken every cycle while the result
// register is empty or is being drained in the same cycle, so the throughput
// is one event per clock. The result register shows the snapshot in the cycle
// after the event is taken; the editor state registers update on the same
// transfer. Events with zero or several buttons pressed leave the panel
// unchanged except for the send-clear input, and still return a snapshot.
// Depends on dpe_pkg and the channel interfaces in dpe_if.sv.
module digit_panel_editor (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dpe_in_if.sink    i_in,
    dpe_out_if.source o_out
);
    import dpe_pkg::*;

    // Editor state
    t_digit [NUM_DIGITS-1:0] r_digits, n_digits;
    t_cursor                 r_cursor, n_cursor;
    logic                    r_send_on, n_send_on;
    logic                    r_read_flag, n_read_flag;

    // Result register
    logic    r_valid;
    t_result r_result, n_result;

    logic in_xfer;

    function automatic t_cursor last_for_mode(input logic [MODE_W-1:0] m);
        if (m == MODE_0 || m == MODE_3)      return t_cursor'(1);
        else if (m == MODE_1 || m == MODE_2) return t_cursor'(4);
        else if (m == MODE_8 || m == MODE_9) return t_cursor'(0);
        else                                 return t_cursor'(3);
    endfunction

    assign i_in.ready = !r_valid || o_out.ready;
    assign in_xfer    = i_in.valid && i_in.ready;

    // Compute the panel after this event
    always_comb begin
        logic [BTN_W-1:0]        btn;
        logic [MODE_W-1:0]       m;
        logic                    single;
        logic                    send_now;
        logic                    stop;
        logic                    up;
        logic                    skip;
        t_cursor                 last;
        t_cursor                 c;
        logic [CURSOR_W:0]       c_inc;
        t_digit [NUM_DIGITS-1:0] d;
        t_digit                  lim;
        t_digit                  step;
        t_digit                  cur;
        logic [DIGIT_W:0]        sum;

        btn      = i_in.buttons;
        m        = i_in.mode;
        single   = (btn != '0) && ((btn & (btn - BTN_W'(1))) == '0);
        send_now = r_send_on && !i_in.send_clear;
        stop     = 1'b0;
        up       = btn[BTN_UP];
        skip     = 1'b0;
        last     = last_for_mode(m);
        c        = r_cursor;
        c_inc    = {1'b0, r_cursor} + (CURSOR_W+1)'(1);
        d        = r_digits;
        lim      = t_digit'(9);
        step     = t_digit'(1);

        n_cursor    = r_cursor;
        n_send_on   = send_now;
        n_read_flag = r_read_flag;

        // Work out limit and step for the digit under the cursor
        if (m == MODE_0) begin
            if (c == t_cursor'(1)) lim = t_digit'(1);
        end else if (m == MODE_1) begin
            lim = t_digit'(9);
        end else if (m == MODE_2) begin
            if (c == t_cursor'(4)) begin
                lim  = t_digit'(10);
                step = t_digit'(10);
            end
            if (c == t_cursor'(3)) lim = t_digit'(1);
        end else if (m == MODE_3) begin
            if (c == t_cursor'(0)) begin
                if (d[0] == t_digit'(1)) d[0] = '0;
                lim  = t_digit'(5);
                step = t_digit'(5);
                if (d[1] > t_digit'(4) && d[1] < t_digit'(9)) skip = 1'b1;
                if (d[1] == t_digit'(9)) begin
                    lim  = t_digit'(9);
                    step = t_digit'(9);
                end
            end else if (c == t_cursor'(1)) begin
                if (d[0] == t_digit'(9)) skip = 1'b1;
                if (d[0] == t_digit'(5)) lim = t_digit'(4);
            end
        end else if (m == MODE_8 || m == MODE_9) begin
            if (c == t_cursor'(0)) lim = t_digit'(1);
        end else begin
            unique case (c)
                t_cursor'(0): lim = (d[3] == t_digit'(4) && d[1] == t_digit'(9))
                                    ? t_digit'(5) : t_digit'(9);
                t_cursor'(1): lim = (d[3] == t_digit'(4) && d[0] > t_digit'(5))
                                    ? t_digit'(8) : t_digit'(9);
                t_cursor'(2): lim = (d[3] == t_digit'(4)) ? t_digit'(0) : t_digit'(9);
                t_cursor'(3): begin
                    if (d[2] > t_digit'(0) ||
                        (d[1] == t_digit'(9) && d[0] > t_digit'(5))) begin
                        lim = t_digit'(3);
                    end else if (m == MODE_6) begin
                        lim = t_digit'(9);
                        if (d[3] > t_digit'(4) || (d[3] == t_digit'(4) && up))
                            step = t_digit'(5);
                    end else begin
                        lim = t_digit'(4);
                    end
                end
                default: lim = t_digit'(9);
            endcase
        end

        // Step the digit with wrap to zero or to the limit
        cur = (c < t_cursor'(NUM_DIGITS)) ? d[c] : '0;
        sum = {1'b0, cur} + {1'b0, step};
        if (up) begin
            cur = (sum > {1'b0, lim}) ? '0 : sum[DIGIT_W-1:0];
        end else begin
            cur = (cur == '0) ? lim : t_digit'(cur - step);
        end

        n_digits = r_digits;
        if (single) begin
            priority if (btn[BTN_LEFT]) begin
                n_cursor = (c_inc > {1'b0, last}) ? '0 : c_inc[CURSOR_W-1:0];
            end else if (btn[BTN_RIGHT]) begin
                n_cursor = (c == '0) ? last : t_cursor'(c - t_cursor'(1));
            end else if (!send_now && (btn[BTN_UP] || btn[BTN_DOWN])) begin
                // Mode 3 clears a one in the rightmost digit, with the cursor on it, even when the edit is refused
                n_digits = d;
                if (!skip && c < t_cursor'(NUM_DIGITS)) n_digits[c] = cur;
            end else if (btn[BTN_SEND]) begin
                if (!send_now) begin
                    n_send_on   = 1'b1;
                    n_read_flag = 1'b0;
                end else begin
                    n_send_on   = 1'b0;
                    n_read_flag = 1'b1;
                    stop        = 1'b1;
                end
            end else begin
                n_cursor = r_cursor;
            end
        end

        n_result.digits       = n_digits;
        n_result.cursor       = n_cursor;
        n_result.last_index   = last;
        n_result.sending      = n_send_on;
        n_result.read_request = n_read_flag;
        n_result.stop_pulse   = stop;
    end

    // Advance state on an input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digits    <= '0;
            r_cursor    <= '0;
            r_send_on   <= 1'b0;
            r_read_flag <= 1'b0;
        end else if (in_xfer) begin
            r_digits    <= n_digits;
            r_cursor    <= n_cursor;
            r_send_on   <= n_send_on;
            r_read_flag <= n_read_flag;
        end
    end

    // Hold the result until the output transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (in_xfer) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) r_result <= n_result;
    end

    assign o_out.valid        = r_valid;
    assign o_out.digit0       = r_result.digits[0];
    assign o_out.digit1       = r_result.digits[1];
    assign o_out.digit2       = r_result.digits[2];
    assign o_out.digit3       = r_result.digits[3];
    assign o_out.digit4       = r_result.digits[4];
    assign o_out.cursor       = r_result.cursor;
    assign o_out.last_index   = r_result.last_index;
    assign o_out.sending      = r_result.sending;
    assign o_out.read_request = r_result.read_request;
    assign o_out.stop_pulse   = r_result.stop_pulse;

endmodule

>>> hw/rtl/dpe_checker.sv
// Port-level checks for the digit panel editor, bound to the editor module.
// Depends on dpe_pkg.
module dpe_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      i_in_ready,
    input logic [dpe_pkg::MODE_W-1:0] i_mode,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input dpe_pkg::t_cursor          i_cursor,
    input dpe_pkg::t_cursor          i_last_index,
    input logic                      i_sending,
    input logic                      i_read_request,
    input logic                      i_stop_pulse
);
    import dpe_pkg::*;

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // Every accepted event shows up as a result in the next cycle
    a_in_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> i_out_valid)
        else $error("accepted event gave no result");

    // Hold a stalled result unchanged until its transfer
    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready)
            |=> (i_out_valid && $stable(i_cursor) && $stable(i_last_index) &&
                 $stable(i_sending) && $stable(i_read_request) && $stable(i_stop_pulse)))
        else $error("stalled result changed");

    // Modes 8 and 9 allow only the rightmost digit
    a_last_mode8: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && (i_mode == MODE_8 || i_mode == MODE_9))
            |=> i_last_index == t_cursor'(0))
        else $error("wrong last index for modes 8 and 9");

    // A stop pulse leaves send mode with a read request and a valid cursor
    a_stop_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_stop_pulse)
            |-> (!i_sending && i_read_request && i_cursor <= t_cursor'(NUM_DIGITS - 1)))
        else $error("stop pulse with inconsistent send state");

endmodule

bind digit_panel_editor dpe_checker u_dpe_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_mode         (i_in.mode),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_cursor       (o_out.cursor),
    .i_last_index   (o_out.last_index),
    .i_sending      (o_out.sending),
    .i_read_request (o_out.read_request),
    .i_stop_pulse   (o_out.stop_pulse)
);
